// ===== design/assert_macros.svh =====
// Assertion macros for the RTL files; the core is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define A2T_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define A2T_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define A2T_ASSERT(lbl, clk, rstn, prop)
`define A2T_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/atan2ti_pkg.sv =====
package atan2ti_pkg;

    localparam int TABLE_SIZE_DEF      = 256;
    localparam int INPUT_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam int Z_W      = 33;
    localparam int FRAC_W   = 32;
    localparam int CORDIC_N = 30;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef logic signed [63:0] s64_t;

    localparam s64_t CORDIC_STEPS [CORDIC_N] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2
    };

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic x_major;
        logic both_zero;
    } quad_t;

    function automatic s64_t pi_round(int drop);
        logic [63:0] v;
        v = (PI_Q60 + (64'd1 << (drop - 1))) >> drop;
        return s64_t'(v);
    endfunction

    // Table entry k holds atan(k/tsize), computed by vectoring rotations in Q30.
    function automatic s64_t atan_entry(int k, int tsize, int fbits);
        s64_t cx;
        s64_t cy;
        s64_t nx;
        s64_t acc;
        s64_t r;
        int   i;
        cx  = s64_t'(tsize) <<< 32;
        cy  = s64_t'(k) <<< 32;
        acc = '0;
        for (i = 0; i < CORDIC_N; i++) begin
            if (cy >= 0) begin
                nx  = cx + (cy >>> i);
                cy  = cy - (cx >>> i);
                acc = acc + CORDIC_STEPS[i];
            end else begin
                nx  = cx - (cy >>> i);
                cy  = cy + (cx >>> i);
                acc = acc - CORDIC_STEPS[i];
            end
            cx = nx;
        end
        r = (acc + (s64_t'(1) <<< (29 - fbits))) >>> (30 - fbits);
        if (k == 0 || r < 0) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== design/atan2ti_div_cell.sv =====
module atan2ti_div_cell #(
    parameter int INPUT_WIDTH = atan2ti_pkg::INPUT_WIDTH_DEF
)(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [INPUT_WIDTH:0]          in_rem,
    input  logic [INPUT_WIDTH-1:0]        in_max,
    input  logic [atan2ti_pkg::Z_W-1:0]   in_q,
    input  atan2ti_pkg::quad_t            in_quad,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [INPUT_WIDTH:0]          out_rem,
    output logic [INPUT_WIDTH-1:0]        out_max,
    output logic [atan2ti_pkg::Z_W-1:0]   out_q,
    output atan2ti_pkg::quad_t            out_quad
);
    import atan2ti_pkg::*;

    localparam int IW = INPUT_WIDTH;

    logic              v_reg;
    logic [IW:0]       rem_reg;
    logic [IW:0]       rem_next;
    logic [IW-1:0]     max_reg;
    logic [Z_W-1:0]    q_reg;
    logic [Z_W-1:0]    q_next;
    quad_t             quad_reg;
    logic              ge;
    logic [IW:0]       diff;
    logic [IW:0]       kept;

    // One quotient bit per cell; the remainder leaves already doubled.
    always_comb begin
        ge       = in_rem >= {1'b0, in_max};
        diff     = in_rem - {1'b0, in_max};
        kept     = ge ? diff : in_rem;
        rem_next = {kept[IW-1:0], 1'b0};
        q_next   = {in_q[Z_W-2:0], ge};
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            max_reg  <= in_max;
            q_reg    <= q_next;
            quad_reg <= in_quad;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_max   = max_reg;
    assign out_q     = q_reg;
    assign out_quad  = quad_reg;

endmodule

// ===== design/atan2ti_rom.sv =====
module atan2ti_rom #(
    parameter int TABLE_SIZE      = atan2ti_pkg::TABLE_SIZE_DEF,
    parameter int ANGLE_FRAC_BITS = atan2ti_pkg::ANGLE_FRAC_BITS_DEF,
    localparam int IDX_W          = $clog2(TABLE_SIZE + 1)
)(
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           addr_lo,
    input  logic [IDX_W-1:0]           addr_hi,
    output logic [ANGLE_FRAC_BITS-1:0] data_lo,
    output logic [ANGLE_FRAC_BITS-1:0] data_hi
);
    import atan2ti_pkg::*;

    logic [ANGLE_FRAC_BITS-1:0] rom_tbl [TABLE_SIZE+1];
    logic [ANGLE_FRAC_BITS-1:0] lo_reg;
    logic [ANGLE_FRAC_BITS-1:0] hi_reg;

    for (genvar k = 0; k <= TABLE_SIZE; k++) begin : g_rom
        localparam s64_t ENTRY = atan_entry(k, TABLE_SIZE, ANGLE_FRAC_BITS);
        assign rom_tbl[k] = ENTRY[ANGLE_FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lo_reg <= rom_tbl[addr_lo];
            hi_reg <= rom_tbl[addr_hi];
        end
    end

    assign data_lo = lo_reg;
    assign data_hi = hi_reg;

endmodule

// ===== design/atan2_table_interpolated_core.sv =====
// Pipeline: one input stage, one divider cell per ratio bit (33), then index, table
// read, multiply, base and fold. Throughput: one item per cycle while m_tready
// holds; every stage is elastic, so bubbles close up.
// Reset: aresetn is synchronous and active low; it empties the pipe and sets
// range_mode to zero. The table is constant and needs no fill after reset.
`include "assert_macros.svh"

module atan2_table_interpolated_core #(
    parameter int TABLE_SIZE      = atan2ti_pkg::TABLE_SIZE_DEF,
    parameter int INPUT_WIDTH     = atan2ti_pkg::INPUT_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = atan2ti_pkg::ANGLE_FRAC_BITS_DEF,
    localparam int IN_TW          = ((2 * INPUT_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW         = ((ANGLE_FRAC_BITS + 4 + 7) / 8) * 8
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // coord_x, coord_y
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // angle
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data   // range_mode
);
    import atan2ti_pkg::*;

    localparam int IW    = INPUT_WIDTH;
    localparam int F     = ANGLE_FRAC_BITS;
    localparam int IDX_W = $clog2(TABLE_SIZE + 1);
    localparam int P_W   = IDX_W + FRAC_W;
    localparam int BW    = F + 1;
    localparam int PR_W  = F + 34;
    localparam int AW    = F + 5;
    localparam int OA_W  = F + 4;

    localparam logic signed [AW-1:0]   PI_F   = AW'(pi_round(60 - F));
    localparam logic signed [AW-1:0]   HALF_F = AW'(pi_round(61 - F));
    localparam logic signed [AW-1:0]   TWO_F  = AW'(pi_round(59 - F));
    localparam logic signed [PR_W-1:0] RND    = PR_W'(s64_t'(1) <<< 31);
    localparam logic [Z_W:0]           SB_RND = (Z_W+1)'(s64_t'(1) <<< (31 - F));
    localparam logic [BW-1:0]          ROM_TOP =
        BW'(atan_entry(TABLE_SIZE, TABLE_SIZE, F));

    logic mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // Input stage: magnitudes, octant flags, smaller over larger.
    logic [IW-1:0] x_in;
    logic [IW-1:0] y_in;
    logic [IW-1:0] ax;
    logic [IW-1:0] ay;
    quad_t         quad_next;
    logic          p_v_reg;
    logic [IW-1:0] p_min_reg;
    logic [IW-1:0] p_max_reg;
    quad_t         p_quad_reg;

    always_comb begin
        x_in = s_tdata[IW-1:0];
        y_in = s_tdata[2*IW-1:IW];
        ax   = x_in[IW-1] ? (~x_in + {{(IW-1){1'b0}}, 1'b1}) : x_in;
        ay   = y_in[IW-1] ? (~y_in + {{(IW-1){1'b0}}, 1'b1}) : y_in;
        quad_next.neg_x     = x_in[IW-1];
        quad_next.neg_y     = y_in[IW-1];
        quad_next.x_major   = ax > ay;
        quad_next.both_zero = (ax == '0) && (ay == '0);
    end

    logic [Z_W:0]   valid_w;
    logic [Z_W:0]   ready_w;
    logic [IW:0]    rem_w  [Z_W+1];
    logic [IW-1:0]  max_w  [Z_W+1];
    logic [Z_W-1:0] q_w    [Z_W+1];
    quad_t          quad_w [Z_W+1];

    assign s_tready = !p_v_reg || ready_w[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (s_tready) begin
            p_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            p_min_reg  <= quad_next.x_major ? ay : ax;
            p_max_reg  <= quad_next.x_major ? ax : ay;
            p_quad_reg <= quad_next;
        end
    end

    assign valid_w[0] = p_v_reg;
    assign rem_w[0]   = {1'b0, p_min_reg};
    assign max_w[0]   = p_max_reg;
    assign q_w[0]     = '0;
    assign quad_w[0]  = p_quad_reg;

    for (genvar k = 0; k < Z_W; k++) begin : g_cell
        atan2ti_div_cell #(
            .INPUT_WIDTH (INPUT_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[k]),
            .in_ready  (ready_w[k]),
            .in_rem    (rem_w[k]),
            .in_max    (max_w[k]),
            .in_q      (q_w[k]),
            .in_quad   (quad_w[k]),
            .out_valid (valid_w[k+1]),
            .out_ready (ready_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_max   (max_w[k+1]),
            .out_q     (q_w[k+1]),
            .out_quad  (quad_w[k+1])
        );
    end

    // Elastic tail stages.
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, m_v_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

    assign e_rdy      = !m_v_reg || m_tready;
    assign d_rdy      = !d_v_reg || e_rdy;
    assign c_rdy      = !c_v_reg || d_rdy;
    assign b_rdy      = !b_v_reg || c_rdy;
    assign a_rdy      = !a_v_reg || b_rdy;
    assign ready_w[Z_W] = a_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_v_reg <= valid_w[Z_W];
            end
            if (b_rdy) begin
                b_v_reg <= a_v_reg;
            end
            if (c_rdy) begin
                c_v_reg <= b_v_reg;
            end
            if (d_rdy) begin
                d_v_reg <= c_v_reg;
            end
            if (e_rdy) begin
                m_v_reg <= d_v_reg;
            end
        end
    end

    // Stage A: table position and the small-ratio angle.
    logic [P_W-1:0]    p_prod;
    logic [Z_W:0]      sb_sum;
    logic [IDX_W-1:0]  a_idx_reg;
    logic [FRAC_W-1:0] a_frac_reg;
    logic              a_small_reg;
    logic [BW-1:0]     a_sbase_reg;
    quad_t             a_quad_reg;

    always_comb begin
        p_prod = P_W'(q_w[Z_W]) * P_W'(TABLE_SIZE);
        sb_sum = {1'b0, q_w[Z_W]} + SB_RND;
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && valid_w[Z_W]) begin
            a_idx_reg   <= p_prod[P_W-1:FRAC_W];
            a_frac_reg  <= p_prod[FRAC_W-1:0];
            a_small_reg <= p_prod[P_W-1:FRAC_W] == '0;
            a_sbase_reg <= sb_sum[FRAC_W:FRAC_W-F];
            a_quad_reg  <= quad_w[Z_W];
        end
    end

    // Stage B: two table reads.
    logic [IDX_W-1:0]  addr_hi;
    logic [F-1:0]      rom_lo;
    logic [F-1:0]      rom_hi;
    logic              b_load;
    logic [FRAC_W-1:0] b_frac_reg;
    logic              b_small_reg;
    logic [BW-1:0]     b_sbase_reg;
    quad_t             b_quad_reg;

    assign addr_hi = (a_idx_reg == IDX_W'(TABLE_SIZE)) ? a_idx_reg
                   : IDX_W'(a_idx_reg + 1'b1);
    assign b_load  = b_rdy && a_v_reg;

    atan2ti_rom #(
        .TABLE_SIZE      (TABLE_SIZE),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (b_load),
        .addr_lo (a_idx_reg),
        .addr_hi (addr_hi),
        .data_lo (rom_lo),
        .data_hi (rom_hi)
    );

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_frac_reg  <= a_frac_reg;
            b_small_reg <= a_small_reg;
            b_sbase_reg <= a_sbase_reg;
            b_quad_reg  <= a_quad_reg;
        end
    end

    // Stage C: slope times fraction.
    logic signed [F:0]      d_s;
    logic signed [PR_W-1:0] c_sum_next;
    logic signed [PR_W-1:0] c_sum_reg;
    logic [F-1:0]           c_lo_reg;
    logic                   c_small_reg;
    logic [BW-1:0]          c_sbase_reg;
    quad_t                  c_quad_reg;

    always_comb begin
        d_s        = $signed({1'b0, rom_hi}) - $signed({1'b0, rom_lo});
        c_sum_next = d_s * $signed({1'b0, b_frac_reg}) + RND;
    end

    always_ff @(posedge aclk) begin
        if (c_rdy && b_v_reg) begin
            c_sum_reg   <= c_sum_next;
            c_lo_reg    <= rom_lo;
            c_small_reg <= b_small_reg;
            c_sbase_reg <= b_sbase_reg;
            c_quad_reg  <= b_quad_reg;
        end
    end

    // Stage D: base angle in the first octant.
    logic signed [F+2:0] interp;
    logic [BW-1:0]       d_base_reg;
    quad_t               d_quad_reg;

    assign interp = $signed({1'b0, c_lo_reg}) + $signed(c_sum_reg[PR_W-1:FRAC_W]);

    always_ff @(posedge aclk) begin
        if (d_rdy && c_v_reg) begin
            d_base_reg <= c_small_reg ? c_sbase_reg : interp[F:0];
            d_quad_reg <= c_quad_reg;
        end
    end

    // Stage E: fold into the octant and apply the output range.
    logic signed [AW-1:0]   base_s;
    logic signed [AW-1:0]   fold;
    logic signed [AW-1:0]   ang_next;
    logic signed [OA_W-1:0] angle_reg;

    always_comb begin
        base_s = $signed({{(AW-BW){1'b0}}, d_base_reg});
        if (d_quad_reg.both_zero) begin
            fold = '0;
        end else if (d_quad_reg.x_major) begin
            if (!d_quad_reg.neg_x) begin
                fold = d_quad_reg.neg_y ? -base_s : base_s;
            end else begin
                fold = d_quad_reg.neg_y ? base_s - PI_F : PI_F - base_s;
            end
        end else begin
            if (!d_quad_reg.neg_y) begin
                fold = d_quad_reg.neg_x ? HALF_F + base_s : HALF_F - base_s;
            end else begin
                fold = d_quad_reg.neg_x ? -HALF_F - base_s : base_s - HALF_F;
            end
        end
        ang_next = (mode_reg && fold < 0) ? fold + TWO_F : fold;
    end

    always_ff @(posedge aclk) begin
        if (e_rdy && d_v_reg) begin
            angle_reg <= ang_next[OA_W-1:0];
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = OUT_TW'($unsigned(angle_reg));

    `A2T_ASSERT_IMPL(a_range_signed, aclk, aresetn, m_v_reg && !mode_reg, angle_reg >= -PI_F && angle_reg <= PI_F)
    `A2T_ASSERT_IMPL(a_range_positive, aclk, aresetn, m_v_reg && mode_reg, angle_reg >= 0)
    `A2T_ASSERT_IMPL(a_base_bound, aclk, aresetn, d_v_reg, d_base_reg <= ROM_TOP)

endmodule
